// File: design/assert_macros.svh
// Shared assertion macros; clk and rst_n come from the module that uses them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Consequent checked in the next cycle.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: design/lmik_pkg.sv
`timescale 1ns / 1ps

package lmik_pkg;

  typedef struct packed {
    logic               command;
    logic [1:0]         leg_select;
    logic [1:0]         axis_select;
    logic signed [15:0] target_position;
    logic signed [15:0] step_size;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         leg_index;
    logic signed [15:0] lift_servo_angle;
    logic signed [15:0] knee_servo_angle;
    logic signed [15:0] yaw_servo_angle;
    logic               unreachable;
    logic               motion_done;
    logic               last_of_tick;
  } out_item_t;

  typedef enum logic [1:0] {
    CFG_UPPER = 2'd0,
    CFG_LOWER = 2'd1,
    CFG_HIP   = 2'd2,
    CFG_TOL   = 2'd3
  } cfg_idx_t;

  localparam logic       CMD_SET  = 1'b0;
  localparam logic       CMD_TICK = 1'b1;
  localparam logic [1:0] AXIS_Z   = 2'd2;
  localparam logic [1:0] LAST_LEG = 2'd3;
  localparam int         NUM_POS  = 12;

  localparam logic [4:0] CORDIC_LAST = 5'd19;
  localparam logic signed [27:0] DEG90  = 28'sd5898240;
  localparam logic signed [27:0] DEG180 = 28'sd11796480;
  localparam logic signed [39:0] NORM_HI = 40'sd1073741824;
  localparam logic signed [39:0] NORM_LO = 40'sd4194304;
  localparam logic [61:0] SQ_BIT_W = 62'd1 << 36;
  localparam logic [61:0] SQ_BIT_S = 62'd1 << 60;

  typedef enum logic [4:0] {
    S_IDLE, S_STEP, S_MXX, S_MYY, S_SQW, S_SQRT, S_VCALC,
    S_MVV, S_MZZ, S_MAA, S_MBB, S_MLO, S_MHI, S_CHK, S_MS, S_SQS,
    S_SROOT, S_AINIT, S_ANORM, S_AITER, S_ADONE, S_EMIT
  } lmik_state_t;

  function automatic logic [21:0] atan_entry(input logic [4:0] i);
    logic [21:0] r;
    unique case (i)
      5'd0:    r = 22'd2949120;
      5'd1:    r = 22'd1740967;
      5'd2:    r = 22'd919879;
      5'd3:    r = 22'd466945;
      5'd4:    r = 22'd234379;
      5'd5:    r = 22'd117304;
      5'd6:    r = 22'd58666;
      5'd7:    r = 22'd29335;
      5'd8:    r = 22'd14668;
      5'd9:    r = 22'd7334;
      5'd10:   r = 22'd3667;
      5'd11:   r = 22'd1833;
      5'd12:   r = 22'd917;
      5'd13:   r = 22'd458;
      5'd14:   r = 22'd229;
      5'd15:   r = 22'd115;
      5'd16:   r = 22'd57;
      5'd17:   r = 22'd29;
      5'd18:   r = 22'd14;
      5'd19:   r = 22'd7;
      default: r = 22'd0;
    endcase
    return r;
  endfunction

endpackage

// File: design/leg_motion_stepper_with_ik_core.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Four-leg foot stepper with three-link inverse kinematics. A set-target item
// writes its target and step when accepted. A tick item steps the three axes
// of a leg, then solves that leg with one shared 32x32 multiplier, a
// bit-serial square root (19 and 31 iterations) and a 20-iteration CORDIC run
// four times. The input is stalled while a tick runs. A result register lets
// the next leg proceed while a result waits. After an unreachable pose the
// block drops all items until reset.
module leg_motion_stepper_with_ik_core import lmik_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  cfg_idx_t  cfg_index,
  input  logic [11:0] cfg_data
);

  lmik_state_t state_r, state_nxt;

  logic [11:0] upper_r, lower_r, hip_r;
  logic [7:0]  tol_r;

  logic signed [15:0] cur_r [NUM_POS];
  logic signed [15:0] tgt_r [NUM_POS];
  logic signed [15:0] stp_r [NUM_POS];

  logic halted_r, halted_nxt;
  logic done_r, done_nxt;
  logic unr_r, unr_nxt;
  logic [1:0] leg_r, leg_nxt, axis_r, axis_nxt;
  logic signed [15:0] px_r, px_nxt, py_r, py_nxt, pz_r, pz_nxt;
  logic signed [63:0] p_r, mul_p;
  logic signed [31:0] mul_a, mul_b;
  logic signed [39:0] acc_r, acc_nxt, r2_r, r2_nxt;
  logic signed [19:0] v_r, v_nxt;
  logic [29:0] aa_r, aa_nxt, bb_r, bb_nxt, lo_r, lo_nxt, hi_r, hi_nxt;
  logic [61:0] sq_n_r, sq_n_nxt, sq_res_r, sq_res_nxt, sq_bit_r, sq_bit_nxt;
  logic sq_sel_r, sq_sel_nxt;
  logic [30:0] s_r, s_nxt;
  logic signed [39:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [27:0] ang_r, ang_nxt;
  logic [4:0] it_r, it_nxt;
  logic [1:0] op_r, op_nxt;
  logic signed [27:0] alpha_r, alpha_nxt, beta_r, beta_nxt, gamma_r, gamma_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic in_acc, set_we, cur_we;
  logic [3:0] pos_idx, in_idx;
  logic signed [15:0] rd_cur, rd_tgt, rd_stp, new_pos;
  logic signed [16:0] rem, sum17;
  logic [16:0] arem, ast;
  logic arrived;
  logic [61:0] sq_t;
  logic [30:0] root;
  logic signed [19:0] w20;
  logic signed [39:0] ox, oy, ay_abs, xs, ys;
  logic signed [39:0] aa40, bb40, z40, s40;
  logic [29:0] ab_sum, ab_dif;
  logic out_free, chk_fail;
  logic signed [27:0] lift_a, knee_a, yaw_a;

  function automatic logic signed [15:0] sat16(input logic signed [16:0] a);
    logic signed [15:0] r;
    if (a > 17'sd32767) r = 16'sh7fff;
    else if (a < -17'sd32768) r = 16'sh8000;
    else r = a[15:0];
    return r;
  endfunction

  function automatic logic signed [15:0] to_servo(input logic signed [27:0] a);
    logic signed [27:0] t;
    logic signed [15:0] r;
    t = (a + 28'sd512) >>> 10;
    if (t > 28'sd32767) r = 16'sh7fff;
    else if (t < -28'sd32768) r = 16'sh8000;
    else r = t[15:0];
    return r;
  endfunction

  assign in_stall  = (state_r != S_IDLE);
  assign in_acc    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign out_free  = !out_valid_r || !out_stall;

  assign pos_idx = {1'b0, leg_r, 1'b0} + {2'b0, leg_r} + {2'b0, axis_r};
  assign in_idx  = {1'b0, in_item.leg_select, 1'b0} + {2'b0, in_item.leg_select}
                 + {2'b0, in_item.axis_select};
  assign set_we  = in_acc && !halted_r && in_item.command == CMD_SET
                 && in_item.axis_select <= AXIS_Z;

  assign rd_cur = cur_r[pos_idx];
  assign rd_tgt = tgt_r[pos_idx];
  assign rd_stp = stp_r[pos_idx];

  // axis stepping
  assign rem     = 17'(rd_tgt) - 17'(rd_cur);
  assign arem    = rem[16] ? 17'(-rem) : 17'(rem);
  assign ast     = rd_stp[15] ? 17'(-17'(rd_stp)) : 17'(17'(rd_stp));
  assign arrived = arem < {9'b0, tol_r};
  assign sum17   = 17'(rd_cur) + 17'(rd_stp);
  assign new_pos = arrived ? rd_cur : ((arem < ast) ? rd_tgt : sat16(sum17));
  assign cur_we  = (state_r == S_STEP);

  // shared multiplier
  assign ab_sum = 30'({upper_r, 2'b0}) + 30'({lower_r, 2'b0});
  assign ab_dif = 30'({upper_r, 2'b0}) - 30'({lower_r, 2'b0});
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MXX: begin mul_a = 32'(px_r); mul_b = 32'(px_r); end
      S_MYY: begin mul_a = 32'(py_r); mul_b = 32'(py_r); end
      S_MVV: begin mul_a = 32'(v_r);  mul_b = 32'(v_r);  end
      S_MZZ: begin mul_a = 32'(z40);  mul_b = 32'(z40);  end
      S_MAA: begin
        mul_a = $signed({18'b0, upper_r, 2'b0});
        mul_b = $signed({18'b0, upper_r, 2'b0});
      end
      S_MBB: begin
        mul_a = $signed({18'b0, lower_r, 2'b0});
        mul_b = $signed({18'b0, lower_r, 2'b0});
      end
      S_MLO: begin
        mul_a = $signed(32'(ab_dif[15:0]) << 16) >>> 16;
        mul_b = $signed(32'(ab_dif[15:0]) << 16) >>> 16;
      end
      S_MHI: begin
        mul_a = $signed({2'b0, ab_sum});
        mul_b = $signed({2'b0, ab_sum});
      end
      S_MS: begin
        mul_a = 32'($signed({10'b0, hi_r}) - r2_r);
        mul_b = 32'(r2_r - $signed({10'b0, lo_r}));
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // square root step and rounded result
  assign sq_t = sq_res_r + sq_bit_r;
  assign root = 31'(sq_res_r) + 31'(sq_n_r > sq_res_r);
  assign w20  = px_r[15] ? -20'(root) : 20'(root);

  // CORDIC operands
  assign aa40 = $signed({10'b0, aa_r});
  assign bb40 = $signed({10'b0, bb_r});
  assign z40  = {{22{pz_r[15]}}, pz_r, 2'b0};
  assign s40  = $signed({9'b0, s_r});
  always_comb begin
    unique case (op_r)
      2'd0: begin oy = z40; ox = 40'(v_r); end
      2'd1: begin oy = s40; ox = aa40 - bb40 + r2_r; end
      2'd2: begin oy = s40; ox = aa40 + bb40 - r2_r; end
      default: begin
        if (!px_r[15]) begin
          oy = 40'(py_r);
          ox = 40'(px_r);
        end else begin
          oy = -40'(py_r);
          ox = -40'(px_r);
        end
      end
    endcase
  end
  assign ay_abs   = cy_r[39] ? -cy_r : cy_r;
  assign xs       = cx_r >>> it_r;
  assign ys       = cy_r >>> it_r;
  assign chk_fail = (r2_r == 40'sd0) || (r2_r < $signed({10'b0, lo_r}))
                  || (r2_r > 40'(p_r));

  // servo mapping
  always_comb begin
    if (leg_r == 2'd0 || leg_r == LAST_LEG) begin
      lift_a = DEG90 - alpha_r;
      knee_a = beta_r;
      yaw_a  = gamma_r + DEG90;
    end else begin
      lift_a = alpha_r + DEG90;
      knee_a = DEG180 - beta_r;
      yaw_a  = DEG90 - gamma_r;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_acc && !halted_r && in_item.command == CMD_TICK) state_nxt = S_STEP;
      end
      S_STEP:  if (axis_r == AXIS_Z) state_nxt = S_MXX;
      S_MXX:   state_nxt = S_MYY;
      S_MYY:   state_nxt = S_SQW;
      S_SQW:   state_nxt = S_SQRT;
      S_SQRT: begin
        if (sq_bit_r == 62'd1) state_nxt = sq_sel_r ? S_SROOT : S_VCALC;
      end
      S_VCALC: state_nxt = S_MVV;
      S_MVV:   state_nxt = S_MZZ;
      S_MZZ:   state_nxt = S_MAA;
      S_MAA:   state_nxt = S_MBB;
      S_MBB:   state_nxt = S_MLO;
      S_MLO:   state_nxt = S_MHI;
      S_MHI:   state_nxt = S_CHK;
      S_CHK:   state_nxt = chk_fail ? S_EMIT : S_MS;
      S_MS:    state_nxt = S_SQS;
      S_SQS:   state_nxt = S_SQRT;
      S_SROOT: state_nxt = S_AINIT;
      S_AINIT: state_nxt = (ox == 40'sd0 && oy == 40'sd0) ? S_ADONE : S_ANORM;
      S_ANORM: begin
        if (!(cx_r < NORM_HI && ay_abs < NORM_HI)) state_nxt = S_AITER;
      end
      S_AITER: if (it_r == CORDIC_LAST) state_nxt = S_ADONE;
      S_ADONE: state_nxt = (op_r == 2'd3) ? S_EMIT : S_AINIT;
      S_EMIT: begin
        if (out_free) state_nxt = (unr_r || leg_r == LAST_LEG) ? S_IDLE : S_STEP;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // datapath
  always_comb begin
    halted_nxt    = halted_r;
    done_nxt      = done_r;
    unr_nxt       = unr_r;
    leg_nxt       = leg_r;
    axis_nxt      = axis_r;
    px_nxt        = px_r;
    py_nxt        = py_r;
    pz_nxt        = pz_r;
    acc_nxt       = acc_r;
    r2_nxt        = r2_r;
    v_nxt         = v_r;
    aa_nxt        = aa_r;
    bb_nxt        = bb_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    sq_n_nxt      = sq_n_r;
    sq_res_nxt    = sq_res_r;
    sq_bit_nxt    = sq_bit_r;
    sq_sel_nxt    = sq_sel_r;
    s_nxt         = s_r;
    cx_nxt        = cx_r;
    cy_nxt        = cy_r;
    ang_nxt       = ang_r;
    it_nxt        = it_r;
    op_nxt        = op_r;
    alpha_nxt     = alpha_r;
    beta_nxt      = beta_r;
    gamma_nxt     = gamma_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    unique case (state_r)
      S_IDLE: begin
        leg_nxt  = 2'd0;
        axis_nxt = 2'd0;
        done_nxt = 1'b1;
        unr_nxt  = 1'b0;
      end
      S_STEP: begin
        if (!arrived) done_nxt = 1'b0;
        unique case (axis_r)
          2'd0:    px_nxt = new_pos;
          2'd1:    py_nxt = new_pos;
          default: pz_nxt = new_pos;
        endcase
        axis_nxt = axis_r + 2'd1;
      end
      S_MYY: acc_nxt = 40'(p_r);
      S_SQW: begin
        sq_n_nxt   = 62'(acc_r + 40'(p_r)) << 4;
        sq_res_nxt = '0;
        sq_bit_nxt = SQ_BIT_W;
        sq_sel_nxt = 1'b0;
      end
      S_SQRT: begin
        if (sq_n_r >= sq_t) begin
          sq_n_nxt   = sq_n_r - sq_t;
          sq_res_nxt = (sq_res_r >> 1) + sq_bit_r;
        end else begin
          sq_res_nxt = sq_res_r >> 1;
        end
        sq_bit_nxt = sq_bit_r >> 2;
      end
      S_VCALC: v_nxt = w20 - $signed({6'b0, hip_r, 2'b0});
      S_MZZ:   acc_nxt = 40'(p_r);
      S_MAA:   r2_nxt = acc_r + 40'(p_r);
      S_MBB:   aa_nxt = p_r[29:0];
      S_MLO:   bb_nxt = p_r[29:0];
      S_MHI:   lo_nxt = p_r[29:0];
      S_CHK: begin
        hi_nxt = p_r[29:0];
        if (chk_fail) unr_nxt = 1'b1;
      end
      S_SQS: begin
        sq_n_nxt   = 62'(p_r);
        sq_res_nxt = '0;
        sq_bit_nxt = SQ_BIT_S;
        sq_sel_nxt = 1'b1;
      end
      S_SROOT: begin
        s_nxt  = root;
        op_nxt = 2'd0;
      end
      S_AINIT: begin
        it_nxt = '0;
        if (ox == 40'sd0 && oy == 40'sd0) begin
          ang_nxt = '0;
        end else if (ox[39]) begin
          ang_nxt = oy[39] ? -DEG180 : DEG180;
          cx_nxt  = -ox;
          cy_nxt  = -oy;
        end else begin
          ang_nxt = '0;
          cx_nxt  = ox;
          cy_nxt  = oy;
        end
      end
      S_ANORM: begin
        if (cx_r < NORM_HI && ay_abs < NORM_HI) begin
          if (cx_r < NORM_LO && ay_abs < NORM_LO) begin
            cx_nxt = cx_r <<< 8;
            cy_nxt = cy_r <<< 8;
          end else begin
            cx_nxt = cx_r <<< 1;
            cy_nxt = cy_r <<< 1;
          end
        end
      end
      S_AITER: begin
        if (!cy_r[39]) begin
          cx_nxt  = cx_r + ys;
          cy_nxt  = cy_r - xs;
          ang_nxt = ang_r + $signed({6'b0, atan_entry(it_r)});
        end else begin
          cx_nxt  = cx_r - ys;
          cy_nxt  = cy_r + xs;
          ang_nxt = ang_r - $signed({6'b0, atan_entry(it_r)});
        end
        it_nxt = it_r + 5'd1;
      end
      S_ADONE: begin
        unique case (op_r)
          2'd0:    alpha_nxt = ang_r;
          2'd1:    alpha_nxt = alpha_r + ang_r;
          2'd2:    beta_nxt  = ang_r;
          default: gamma_nxt = ang_r;
        endcase
        op_nxt = op_r + 2'd1;
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_nxt          = 1'b1;
          out_item_nxt.leg_index = leg_r;
          if (unr_r) begin
            out_item_nxt.lift_servo_angle = '0;
            out_item_nxt.knee_servo_angle = '0;
            out_item_nxt.yaw_servo_angle  = '0;
            out_item_nxt.unreachable      = 1'b1;
            out_item_nxt.motion_done      = 1'b0;
            out_item_nxt.last_of_tick     = 1'b1;
            halted_nxt                    = 1'b1;
          end else begin
            out_item_nxt.lift_servo_angle = to_servo(lift_a);
            out_item_nxt.knee_servo_angle = to_servo(knee_a);
            out_item_nxt.yaw_servo_angle  = to_servo(yaw_a);
            out_item_nxt.unreachable      = 1'b0;
            out_item_nxt.motion_done      = (leg_r == LAST_LEG) && done_r;
            out_item_nxt.last_of_tick     = (leg_r == LAST_LEG);
          end
          leg_nxt  = leg_r + 2'd1;
          axis_nxt = 2'd0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      halted_r    <= 1'b0;
      out_valid_r <= 1'b0;
      upper_r     <= 12'd880;
      lower_r     <= 12'd1240;
      hip_r       <= 12'd440;
      tol_r       <= 8'd1;
      for (int i = 0; i < NUM_POS; i++) begin
        cur_r[i] <= '0;
        tgt_r[i] <= '0;
        stp_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      halted_r    <= halted_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_UPPER: upper_r <= cfg_data;
          CFG_LOWER: lower_r <= cfg_data;
          CFG_HIP:   hip_r   <= cfg_data;
          CFG_TOL:   tol_r   <= cfg_data[7:0];
        endcase
      end
      if (set_we) begin
        tgt_r[in_idx] <= in_item.target_position;
        stp_r[in_idx] <= in_item.step_size;
      end
      if (cur_we) cur_r[pos_idx] <= new_pos;
    end
  end

  always_ff @(posedge clk) begin
    done_r     <= done_nxt;
    unr_r      <= unr_nxt;
    leg_r      <= leg_nxt;
    axis_r     <= axis_nxt;
    px_r       <= px_nxt;
    py_r       <= py_nxt;
    pz_r       <= pz_nxt;
    p_r        <= mul_p;
    acc_r      <= acc_nxt;
    r2_r       <= r2_nxt;
    v_r        <= v_nxt;
    aa_r       <= aa_nxt;
    bb_r       <= bb_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    sq_n_r     <= sq_n_nxt;
    sq_res_r   <= sq_res_nxt;
    sq_bit_r   <= sq_bit_nxt;
    sq_sel_r   <= sq_sel_nxt;
    s_r        <= s_nxt;
    cx_r       <= cx_nxt;
    cy_r       <= cy_nxt;
    ang_r      <= ang_nxt;
    it_r       <= it_nxt;
    op_r       <= op_nxt;
    alpha_r    <= alpha_nxt;
    beta_r     <= beta_nxt;
    gamma_r    <= gamma_nxt;
    out_item_r <= out_item_nxt;
  end

  `ASSERT_NXT(a_halt_quiet, halted_r && !out_valid_r, !out_valid_r)
  `ASSERT_IMP(a_unr_last, out_valid_r && out_item_r.unreachable, out_item_r.last_of_tick && !out_item_r.motion_done)
  `ASSERT_IMP(a_sqrt_bit, state_r == S_SQRT, $onehot(sq_bit_r))

endmodule
